[src/cbe_pkg.sv]
// cbe_pkg: shared types and register codes for the cubic bezier easing solver
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package cbe_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_X1 = 2'd0,
        CFG_Y1 = 2'd1,
        CFG_X2 = 2'd2,
        CFG_Y2 = 2'd3
    } t_cfg_idx;

    localparam int CFG_IDX_W = 2;

    // control that travels with each word down the pipeline
    typedef struct packed {
        logic valid;
        logic is_zero;  // progress at zero, result forced to zero
        logic is_one;   // progress at or above one, result forced to one
    } t_item_ctl;

endpackage

`default_nettype wire

[src/cbe_basis.sv]
// cbe_basis: two-stage bernstein basis terms o^2*g, o*g^2, g^3 for a guess g
// uses cbe_pkg only through the common import style
`timescale 1ns / 1ps
`default_nettype none

module cbe_basis #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic [FRAC_BITS:0]   i_g,
    output logic      [FRAC_BITS:0]   o_oog,
    output logic      [FRAC_BITS:0]   o_ogg,
    output logic      [FRAC_BITS:0]   o_ggg
);
    import cbe_pkg::*;

    localparam int W  = FRAC_BITS + 1;
    localparam int PW = 2 * W;
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

    logic [W-1:0]  w_o;
    logic [PW-1:0] w_og_full, w_gg_full;
    logic [W-1:0]  r_o, r_g, r_og, r_gg;
    logic [PW-1:0] w_oog_full, w_ogg_full, w_ggg_full;
    logic [W-1:0]  r_oog, r_ogg, r_ggg;

    // stage 1: o*g and g*g
    assign w_o       = ONE - i_g;
    assign w_og_full = PW'(w_o) * PW'(i_g);
    assign w_gg_full = PW'(i_g) * PW'(i_g);

    always_ff @(posedge i_clk) begin
        r_o  <= w_o;
        r_g  <= i_g;
        r_og <= w_og_full[FRAC_BITS +: W];
        r_gg <= w_gg_full[FRAC_BITS +: W];
    end

    // stage 2: cubic terms
    assign w_oog_full = PW'(r_o) * PW'(r_og);
    assign w_ogg_full = PW'(r_g) * PW'(r_og);
    assign w_ggg_full = PW'(r_g) * PW'(r_gg);

    always_ff @(posedge i_clk) begin
        r_oog <= w_oog_full[FRAC_BITS +: W];
        r_ogg <= w_ogg_full[FRAC_BITS +: W];
        r_ggg <= w_ggg_full[FRAC_BITS +: W];
    end

    assign o_oog = r_oog;
    assign o_ogg = r_ogg;
    assign o_ggg = r_ggg;

endmodule

`default_nettype wire

[src/cbe_bisect_step.sv]
// cbe_bisect_step: one three-stage bisection step on the x polynomial
// depends on cbe_pkg (t_item_ctl) and cbe_basis
`timescale 1ns / 1ps
`default_nettype none

module cbe_bisect_step #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire cbe_pkg::t_item_ctl   i_ctl,
    input  wire logic [FRAC_BITS-1:0] i_p,
    input  wire logic [FRAC_BITS:0]   i_lo,
    input  wire logic [FRAC_BITS:0]   i_hi,
    input  wire logic [FRAC_BITS:0]   i_g,
    input  wire logic [FRAC_BITS:0]   i_x1,
    input  wire logic [FRAC_BITS:0]   i_x2,
    output cbe_pkg::t_item_ctl        o_ctl,
    output logic      [FRAC_BITS-1:0] o_p,
    output logic      [FRAC_BITS:0]   o_lo,
    output logic      [FRAC_BITS:0]   o_hi,
    output logic      [FRAC_BITS:0]   o_g
);
    import cbe_pkg::*;

    localparam int W  = FRAC_BITS + 1;
    localparam int XW = 2 * FRAC_BITS + 6;

    logic [W-1:0] w_oog, w_ogg, w_ggg;

    cbe_basis #(.FRAC_BITS(FRAC_BITS)) u_basis (
        .i_clk (i_clk),
        .i_g   (i_g),
        .o_oog (w_oog),
        .o_ogg (w_ogg),
        .o_ggg (w_ggg)
    );

    // side data follows the basis latency
    t_item_ctl            r_ctl_d1, r_ctl_d2, r_ctl;
    logic [FRAC_BITS-1:0] r_p_d1, r_p_d2, r_p;
    logic [W-1:0]         r_lo_d1, r_lo_d2, r_hi_d1, r_hi_d2, r_g_d1, r_g_d2;
    logic [W-1:0]         r_lo, r_hi, r_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_d1 <= '0;
            r_ctl_d2 <= '0;
            r_ctl    <= '0;
        end else begin
            r_ctl_d1 <= i_ctl;
            r_ctl_d2 <= r_ctl_d1;
            r_ctl    <= r_ctl_d2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_d1  <= i_p;
        r_p_d2  <= r_p_d1;
        r_lo_d1 <= i_lo;
        r_lo_d2 <= r_lo_d1;
        r_hi_d1 <= i_hi;
        r_hi_d2 <= r_hi_d1;
        r_g_d1  <= i_g;
        r_g_d2  <= r_g_d1;
    end

    // stage 3: x(g) against p and interval update
    logic [XW-1:0] w_mix, w_xv, w_pt;
    logic          w_lt;
    logic [W-1:0]  n_lo, n_hi;
    logic [W:0]    w_mid;

    assign w_mix = XW'(w_oog) * XW'(i_x1) + XW'(w_ogg) * XW'(i_x2);
    assign w_xv  = (w_mix << 1) + w_mix + (XW'(w_ggg) << FRAC_BITS);
    assign w_pt  = XW'(r_p_d2) << FRAC_BITS;
    assign w_lt  = w_xv < w_pt;
    assign n_lo  = w_lt ? r_g_d2 : r_lo_d2;
    assign n_hi  = w_lt ? r_hi_d2 : r_g_d2;
    assign w_mid = (W + 1)'(n_lo) + (W + 1)'(n_hi);

    always_ff @(posedge i_clk) begin
        r_p  <= r_p_d2;
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_g  <= w_mid[W:1];
    end

    assign o_ctl = r_ctl;
    assign o_p   = r_p;
    assign o_lo  = r_lo;
    assign o_hi  = r_hi;
    assign o_g   = r_g;

endmodule

`default_nettype wire

[src/cubic_bezier_easing_solver.sv]
// cubic_bezier_easing_solver: top level, configuration registers, bisection chain
// and y evaluation; depends on cbe_pkg, cbe_basis and cbe_bisect_step
//
// Usage
//   Input channel: drive i_progress (unsigned, FRAC_BITS fraction bits) and raise
//   start; the word is taken at each rising edge where start is high and busy low.
//   busy is high only during reset and the cycle after, so a word can enter every
//   cycle.
//   Output: o_valid strobes for one cycle with o_eased_value (signed Q2.F,
//   saturated). Results come out in input order; the receiver cannot stall them.
//   Pipeline: each bisection step is three register stages (o*g and g*g,
//   cubic basis terms, x products and compare), then two basis stages and one
//   stage for y and saturation. Throughput is one word per cycle.
//   Configuration: write channel i_cfg_valid/o_cfg_ready with i_cfg_index and
//   i_cfg_data; o_cfg_ready is always high. Write only while no word is in flight.
//   Reset (synchronous, active low) empties the pipeline and loads the control
//   points (0,0) and (1,1).
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_easing_solver #(
    parameter int BISECT_STEPS = 20,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [FRAC_BITS:0]            i_progress,
    output logic                               o_valid,
    output logic signed [FRAC_BITS+2:0]        o_eased_value,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [cbe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [FRAC_BITS+2:0]          i_cfg_data
);
    import cbe_pkg::*;

    localparam int W  = FRAC_BITS + 1;
    localparam int YO = FRAC_BITS + 3;
    localparam int YW = 2 * FRAC_BITS + 9;
    localparam logic [W-1:0]           ONE   = W'(1) << FRAC_BITS;
    localparam logic signed [YW-1:0]   Y_MAX = YW'(2) << FRAC_BITS;
    localparam logic signed [YW-1:0]   Y_MIN = -Y_MAX;

    // configuration registers
    logic [W-1:0]         r_x1, r_x2;
    logic signed [YO-1:0] r_y1, r_y2;
    t_cfg_idx             w_idx;

    assign o_cfg_ready = 1'b1;
    assign w_idx       = t_cfg_idx'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_y1 <= '0;
            r_x2 <= ONE;
            r_y2 <= YO'(ONE);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (w_idx)
                CFG_X1:  r_x1 <= i_cfg_data[W-1:0];
                CFG_Y1:  r_y1 <= i_cfg_data;
                CFG_X2:  r_x2 <= i_cfg_data[W-1:0];
                CFG_Y2:  r_y2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // busy only around reset
    logic r_run;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end
    assign busy = !r_run;

    // input stage
    t_item_ctl            w_in_ctl;
    t_item_ctl            c_ctl [BISECT_STEPS+1];
    logic [FRAC_BITS-1:0] c_p   [BISECT_STEPS+1];
    logic [W-1:0]         c_lo  [BISECT_STEPS+1];
    logic [W-1:0]         c_hi  [BISECT_STEPS+1];
    logic [W-1:0]         c_g   [BISECT_STEPS+1];

    assign w_in_ctl.valid   = start && !busy;
    assign w_in_ctl.is_zero = (i_progress == '0);
    assign w_in_ctl.is_one  = i_progress[FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_ctl[0] <= '0;
        end else begin
            c_ctl[0] <= w_in_ctl;
        end
    end

    // special inputs run a harmless guess of zero
    always_ff @(posedge i_clk) begin
        c_p[0]  <= i_progress[FRAC_BITS-1:0];
        c_lo[0] <= '0;
        c_hi[0] <= ONE;
        c_g[0]  <= i_progress[FRAC_BITS] ? '0 : i_progress;
    end

    for (genvar k = 0; k < BISECT_STEPS; k++) begin : g_step
        cbe_bisect_step #(.FRAC_BITS(FRAC_BITS)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (c_ctl[k]),
            .i_p     (c_p[k]),
            .i_lo    (c_lo[k]),
            .i_hi    (c_hi[k]),
            .i_g     (c_g[k]),
            .i_x1    (r_x1),
            .i_x2    (r_x2),
            .o_ctl   (c_ctl[k+1]),
            .o_p     (c_p[k+1]),
            .o_lo    (c_lo[k+1]),
            .o_hi    (c_hi[k+1]),
            .o_g     (c_g[k+1])
        );
    end

    // y evaluation at the final guess
    logic [W-1:0] w_oog, w_ogg, w_ggg;

    cbe_basis #(.FRAC_BITS(FRAC_BITS)) u_basis_y (
        .i_clk (i_clk),
        .i_g   (c_g[BISECT_STEPS]),
        .o_oog (w_oog),
        .o_ogg (w_ogg),
        .o_ggg (w_ggg)
    );

    t_item_ctl r_yctl_d1, r_yctl_d2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yctl_d1 <= '0;
            r_yctl_d2 <= '0;
        end else begin
            r_yctl_d1 <= c_ctl[BISECT_STEPS];
            r_yctl_d2 <= r_yctl_d1;
        end
    end

    logic signed [YW-1:0] s_oog, s_ogg, s_ggg, s_y1, s_y2, s_mix, s_sum, s_fl, s_sat;
    logic signed [YO-1:0] n_eased;

    assign s_oog = {{(YW-W){1'b0}}, w_oog};
    assign s_ogg = {{(YW-W){1'b0}}, w_ogg};
    assign s_ggg = {{(YW-W){1'b0}}, w_ggg};
    assign s_y1  = {{(YW-YO){r_y1[YO-1]}}, r_y1};
    assign s_y2  = {{(YW-YO){r_y2[YO-1]}}, r_y2};
    assign s_mix = s_oog * s_y1 + s_ogg * s_y2;
    assign s_sum = (s_mix <<< 1) + s_mix + (s_ggg <<< FRAC_BITS);
    assign s_fl  = s_sum >>> FRAC_BITS;   // floor toward minus infinity
    assign s_sat = (s_fl > Y_MAX) ? Y_MAX : ((s_fl < Y_MIN) ? Y_MIN : s_fl);

    always_comb begin
        if (r_yctl_d2.is_zero) begin
            n_eased = '0;
        end else if (r_yctl_d2.is_one) begin
            n_eased = YO'(ONE);
        end else begin
            n_eased = s_sat[YO-1:0];
        end
    end

    logic                 r_valid;
    logic signed [YO-1:0] r_eased;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_yctl_d2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eased <= n_eased;
    end

    assign o_valid       = r_valid;
    assign o_eased_value = r_eased;

endmodule

`default_nettype wire
